// ===== hdl/ecs_pkg.sv =====
`default_nettype none
package ecs_pkg;

  localparam int NUM_TERMS    = 6;
  localparam int TAYLOR_STEPS = 7;
  localparam int POW_STAGES   = NUM_TERMS - 1;
  localparam int SINE_LAT     = 3 + 3 * TAYLOR_STEPS + 1;
  localparam int POW_DLY      = SINE_LAT - POW_STAGES;
  localparam int TERM_LAT     = 4;
  localparam int PIPE_LAT     = 1 + SINE_LAT + TERM_LAT + 2;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_Q30    = 64'd536870912;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [7:0] TAYLOR_DIV [TAYLOR_STEPS] = '{
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };

  // floor(2^32 / d)
  localparam logic [29:0] TAYLOR_RECIP [TAYLOR_STEPS] = '{
    30'(64'h1_0000_0000 / 64'd210), 30'(64'h1_0000_0000 / 64'd156),
    30'(64'h1_0000_0000 / 64'd110), 30'(64'h1_0000_0000 / 64'd72),
    30'(64'h1_0000_0000 / 64'd42),  30'(64'h1_0000_0000 / 64'd20),
    30'(64'h1_0000_0000 / 64'd6)
  };

  // term = (a * num + den/2) / den, den = 2^shift * odd
  localparam logic [10:0] COEF_NUM [NUM_TERMS] = '{
    11'd2, 11'd5, 11'd13, 11'd103, 11'd1097, 11'd1223
  };
  localparam logic [8:0] COEF_HALF [NUM_TERMS] = '{
    9'd0, 9'd2, 9'd6, 9'd48, 9'd480, 9'd480
  };
  localparam logic [2:0] COEF_SHIFT [NUM_TERMS] = '{
    3'd0, 3'd2, 3'd2, 3'd5, 3'd6, 3'd6
  };
  localparam logic [3:0] COEF_ODIV [NUM_TERMS] = '{
    4'd1, 4'd1, 4'd3, 4'd3, 4'd15, 4'd15
  };
  // floor(2^35 / odd), unused for odd == 1
  localparam logic [33:0] COEF_RECIP [NUM_TERMS] = '{
    34'd0, 34'd0,
    34'(64'h8_0000_0000 / 64'd3), 34'(64'h8_0000_0000 / 64'd3),
    34'(64'h8_0000_0000 / 64'd15), 34'(64'h8_0000_0000 / 64'd15)
  };

  typedef struct packed {
    logic        neg;
    logic [30:0] x;
    logic [31:0] x2;
  } sin_ctx_t;

endpackage
`default_nettype wire

// ===== hdl/equation_of_centre_series_core.sv =====
// Equation of centre, six-harmonic series, fixed point.
// Input stream: s_axis_tdata_i = {eccentricity Q0.16, mean_anomaly turn fraction}.
// Output stream: m_axis_tdata_o = centre offset, signed Q4.28 radians.
// One transaction in gives exactly one transaction out, in order.
// Config channel: cfg_data_i sets the number of harmonics (1..6); other values are
// dropped. Write it only while the pipeline is empty. Reset value is 6.
// Pipeline: the sine pipeline (phase fold, two multiplies, seven three-stage Taylor
// steps, final multiply), then four coefficient stages, a two-stage adder tree and
// the rounding register.
// Throughput: one transaction per cycle while the receiver accepts; no multiplier is
// shared between stages, and each harmonic lane has its own sine and term pipelines.
// Reset clears all valid bits and restores the harmonic count.
// When the receiver stalls, the whole pipeline holds and s_axis_tready_o drops;
// nothing is lost or repeated.
`default_nettype none
module equation_of_centre_series_core
  import ecs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // [31:0] mean_anomaly, [47:32] eccentricity
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [31:0] centre_offset
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_data_i
);

  logic        en;
  logic [2:0]  term_count_q;
  logic [PIPE_LAT:0] vld_q;
  logic [31:0] m_q;
  logic [15:0] e_q;
  logic [29:0] p_w   [NUM_TERMS];
  logic [30:0] s_w   [NUM_TERMS];
  logic        neg_w [NUM_TERMS];
  logic signed [35:0] term_w [NUM_TERMS];
  logic signed [35:0] gated  [NUM_TERMS];
  logic signed [36:0] part_q [NUM_TERMS/2];
  logic signed [37:0] acc_q;
  logic [37:0] mag;
  logic [31:0] res_d, res_q;

  assign en              = !vld_q[PIPE_LAT] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= 3'(NUM_TERMS);
    end else if (cfg_valid_i && cfg_data_i >= 3'd1 && cfg_data_i <= 3'(NUM_TERMS)) begin
      term_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-1:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q <= s_axis_tdata_i[31:0];
      e_q <= s_axis_tdata_i[47:32];
    end
  end

  ecs_power u_power (
    .clk_i (clk_i),
    .en_i  (en),
    .ecc_i (e_q),
    .p_o   (p_w)
  );

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_lane
    logic [31:0] phase;
    assign phase = 32'(m_q * 32'(k + 1));

    ecs_sine u_sine (
      .clk_i   (clk_i),
      .en_i    (en),
      .phase_i (phase),
      .neg_o   (neg_w[k]),
      .s_o     (s_w[k])
    );

    ecs_term u_term (
      .clk_i    (clk_i),
      .en_i     (en),
      .p_i      (p_w[k]),
      .s_i      (s_w[k]),
      .neg_i    (neg_w[k]),
      .num_i    (COEF_NUM[k]),
      .half_i   (COEF_HALF[k]),
      .shift_i  (COEF_SHIFT[k]),
      .odiv_i   (COEF_ODIV[k]),
      .orecip_i (COEF_RECIP[k]),
      .term_o   (term_w[k])
    );

    assign gated[k] = (3'(k) < term_count_q) ? term_w[k] : '0;
  end

  always_comb begin
    if (acc_q < 0) begin
      mag   = 38'(-acc_q + 38'sd2) >> 2;
      res_d = (mag > 38'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
    end else begin
      mag   = 38'(acc_q + 38'sd2) >> 2;
      res_d = (mag > 38'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_TERMS / 2; i++) begin
        part_q[i] <= 37'(gated[2*i]) + 37'(gated[2*i+1]);
      end
      acc_q <= 38'(part_q[0]) + 38'(part_q[1]) + 38'(part_q[2]);
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[PIPE_LAT];
  assign m_axis_tdata_o  = res_q;

endmodule
`default_nettype wire

// ===== hdl/ecs_horner.sv =====
`default_nettype none
module ecs_horner
  import ecs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [7:0]  div_i,
  input  wire logic [29:0] recip_i,
  input  wire sin_ctx_t    ctx_i,
  input  wire logic [30:0] r_i,
  output sin_ctx_t         ctx_o,
  output logic [30:0]      r_o
);

  sin_ctx_t    ctx1_q, ctx2_q, ctx3_q;
  logic [31:0] v1_q, v2_q;
  logic [29:0] q0_q;
  logic [30:0] r_q, r_d;
  logic [62:0] prod1;
  logic [61:0] prod2;
  logic [37:0] prod3, rem;
  logic [30:0] q;

  assign prod1 = 63'(ctx_i.x2) * 63'(r_i) + 63'(HALF_Q30);
  assign prod2 = 62'(v1_q) * 62'(recip_i);
  assign prod3 = 38'(q0_q) * 38'(div_i);
  assign rem   = 38'(v2_q) - prod3;

  always_comb begin
    q   = 31'(q0_q) + 31'(rem >= 38'(div_i));
    r_d = (q >= 31'(ONE_Q30)) ? '0 : 31'(ONE_Q30) - q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q <= ctx_i;
      v1_q   <= prod1[61:30];
      ctx2_q <= ctx1_q;
      v2_q   <= v1_q;
      q0_q   <= prod2[61:32];
      ctx3_q <= ctx2_q;
      r_q    <= r_d;
    end
  end

  assign ctx_o = ctx3_q;
  assign r_o   = r_q;

endmodule
`default_nettype wire

// ===== hdl/ecs_sine.sv =====
`default_nettype none
module ecs_sine
  import ecs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] phase_i,
  output logic             neg_o,
  output logic [30:0]      s_o
);

  logic        neg1_q, neg2_q, neg_q;
  logic [30:0] u_q, u_d, x_q, s_q;
  sin_ctx_t    ctx_q;
  logic [61:0] xprod, x2prod, sprod;
  sin_ctx_t    ctx_w [TAYLOR_STEPS+1];
  logic [30:0] r_w   [TAYLOR_STEPS+1];

  assign u_d    = phase_i[30] ? 31'(ONE_Q30) - {1'b0, phase_i[29:0]} : {1'b0, phase_i[29:0]};
  assign xprod  = 62'(u_q) * 62'(HALF_PI_Q30) + 62'(HALF_Q30);
  assign x2prod = 62'(x_q) * 62'(x_q) + 62'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q    <= phase_i[31];
      u_q       <= u_d;
      neg2_q    <= neg1_q;
      x_q       <= xprod[60:30];
      ctx_q.neg <= neg2_q;
      ctx_q.x   <= x_q;
      ctx_q.x2  <= x2prod[61:30];
    end
  end

  assign ctx_w[0] = ctx_q;
  assign r_w[0]   = 31'(ONE_Q30);

  for (genvar i = 0; i < TAYLOR_STEPS; i++) begin : g_step
    ecs_horner u_horner (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .div_i   (TAYLOR_DIV[i]),
      .recip_i (TAYLOR_RECIP[i]),
      .ctx_i   (ctx_w[i]),
      .r_i     (r_w[i]),
      .ctx_o   (ctx_w[i+1]),
      .r_o     (r_w[i+1])
    );
  end

  assign sprod = 62'(ctx_w[TAYLOR_STEPS].x) * 62'(r_w[TAYLOR_STEPS]) + 62'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= ctx_w[TAYLOR_STEPS].neg;
      s_q   <= sprod[60:30];
    end
  end

  assign neg_o = neg_q;
  assign s_o   = s_q;

endmodule
`default_nettype wire

// ===== hdl/ecs_power.sv =====
`default_nettype none
module ecs_power
  import ecs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] ecc_i,
  output logic [29:0]      p_o [NUM_TERMS]
);

  logic [29:0] stg_q [POW_STAGES][NUM_TERMS];
  logic [29:0] stg_d [POW_STAGES][NUM_TERMS];
  logic [29:0] pin   [POW_STAGES][NUM_TERMS];
  logic [15:0] ecc_q [POW_STAGES];
  logic [15:0] ein   [POW_STAGES];
  logic [45:0] prod  [POW_STAGES];
  logic [29:0] dly_q [POW_DLY][NUM_TERMS];

  for (genvar j = 0; j < POW_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < NUM_TERMS; k++) begin
          pin[j][k] = '0;
        end
        pin[j][0] = {ecc_i, 14'd0};
        ein[j]    = ecc_i;
      end
    end else begin : g_next
      always_comb begin
        pin[j] = stg_q[j-1];
        ein[j] = ecc_q[j-1];
      end
    end

    assign prod[j] = 46'(pin[j][j]) * 46'(ein[j]) + 46'd32768;

    always_comb begin
      stg_d[j]      = pin[j];
      stg_d[j][j+1] = prod[j][45:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q    <= stg_d;
      ecc_q[0] <= ecc_i;
      for (int j = 1; j < POW_STAGES; j++) begin
        ecc_q[j] <= ecc_q[j-1];
      end
      dly_q[0] <= stg_q[POW_STAGES-1];
      for (int i = 1; i < POW_DLY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign p_o = dly_q[POW_DLY-1];

endmodule
`default_nettype wire

// ===== hdl/ecs_term.sv =====
`default_nettype none
module ecs_term
  import ecs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [29:0] p_i,
  input  wire logic [30:0] s_i,
  input  wire logic        neg_i,
  input  wire logic [10:0] num_i,
  input  wire logic [8:0]  half_i,
  input  wire logic [2:0]  shift_i,
  input  wire logic [3:0]  odiv_i,
  input  wire logic [33:0] orecip_i,
  output logic signed [35:0] term_o
);

  logic        neg1_q, neg2_q, neg3_q;
  logic [30:0] a_q;
  logic [34:0] w_q, w2_q, q0_q, q0_d, q;
  logic [60:0] aprod;
  logic [41:0] wprod, wsh;
  logic [68:0] rprod;
  logic [38:0] mprod, rem;
  logic signed [35:0] term_q;

  assign aprod = 61'(p_i) * 61'(s_i) + 61'(HALF_Q30);
  assign wprod = 42'(a_q) * 42'(num_i) + 42'(half_i);
  assign wsh   = wprod >> shift_i;
  assign rprod = 69'(w_q) * 69'(orecip_i);
  assign q0_d  = (odiv_i == 4'd1) ? w_q : 35'(rprod[68:35]);
  assign mprod = 39'(q0_q) * 39'(odiv_i);
  assign rem   = 39'(w2_q) - mprod;
  assign q     = q0_q + 35'(rem >= 39'(odiv_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg_i;
      a_q    <= aprod[60:30];
      neg2_q <= neg1_q;
      w_q    <= wsh[34:0];
      neg3_q <= neg2_q;
      w2_q   <= w_q;
      q0_q   <= q0_d;
      term_q <= neg3_q ? -$signed(36'(q)) : $signed(36'(q));
    end
  end

  assign term_o = term_q;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ecs_pkg::*;

  localparam int DRAIN_CYCLES = PIPE_LAT + 16;
  localparam longint CYCLE_LIMIT = 400000;

  localparam logic [63:0] HALF_E16 = 64'd32768;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;  // [31:0] mean_anomaly, [47:32] eccentricity
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;  // [31:0] centre_offset
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;

  logic [2:0]  harmonics;
  logic [31:0] offset_q[$];
  int          err_cnt;
  longint      cyc;
  bit          rx_hold;
  bit          rx_no_stall;

  equation_of_centre_series_core DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] sine_magnitude(input logic [31:0] phase, output bit neg);
    logic [63:0] t, u, x, x2, r, q;
    logic [63:0] divs[7];
    divs = '{64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    t = {34'd0, phase[29:0]};
    u = phase[30] ? ONE_Q30 - t : t;
    x = (u * HALF_PI_Q30 + HALF_Q30) >> 30;
    x2 = (x * x + HALF_Q30) >> 30;
    r = ONE_Q30;
    for (int i = 0; i < 7; i++) begin
      q = ((x2 * r + HALF_Q30) >> 30) / divs[i];
      r = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    end
    neg = phase[31];
    return (x * r + HALF_Q30) >> 30;
  endfunction

  function automatic logic [31:0] centre_offset(input logic [31:0] m, input logic [15:0] e,
                                                input logic [2:0] n);
    logic [63:0] nums[6];
    logic [63:0] dens[6];
    logic [63:0] p, s, a, term, mag;
    logic signed [63:0] acc;
    logic [31:0] phase;
    bit neg;
    nums = '{64'd2, 64'd5, 64'd13, 64'd103, 64'd1097, 64'd1223};
    dens = '{64'd1, 64'd4, 64'd12, 64'd96, 64'd960, 64'd960};
    p = {48'd0, e} << 14;
    acc = 0;
    for (int k = 0; k < n && k < 6; k++) begin
      phase = 32'((k + 1) * m);
      s = sine_magnitude(phase, neg);
      if (k > 0) p = (p * e + HALF_E16) >> 16;
      a = (p * s + HALF_Q30) >> 30;
      term = (a * nums[k] + dens[k] / 2) / dens[k];
      if (neg) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) begin
      mag = (64'(-acc) + 2) >> 2;
      return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    end
    mag = (64'(acc) + 2) >> 2;
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, optional long hold-off
  initial begin
    int n;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
      end else if (rx_no_stall || $urandom_range(0, 2) != 0) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        n = 1 + gap_len();
        repeat (n) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (offset_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, m_axis_tdata_o);
        err_cnt++;
      end else begin
        if (offset_q[0] !== m_axis_tdata_o) begin
          $display("%0t: centre_offset expected %h actual %h",
                   $time, offset_q[0], m_axis_tdata_o);
          err_cnt++;
        end
        void'(offset_q.pop_front());
      end
    end
  end

  task automatic send_item(input logic [31:0] m, input logic [15:0] e, input bit gaps = 1);
    int n;
    if (gaps) begin
      n = gap_len();
      if (n > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {e, m};
    do @(posedge clk_i); while (!s_axis_tready_o);
    offset_q.push_back(centre_offset(m, e, harmonics));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (offset_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_harmonics(input logic [2:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (v >= 1 && v <= NUM_TERMS) harmonics = v;
  endtask

  task automatic test_directed();
    logic [31:0] angles[8];
    angles = '{32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h8000_0000,
               32'hC000_0000, 32'h2000_0000, 32'h3FFF_FFFF, 32'h0000_0001};
    foreach (angles[i]) send_item(angles[i], 16'hFFFF);
    send_item(32'h1234_5678, 16'h0000);
    send_item(32'hFFFF_FFFF, 16'h0000);
    send_item(32'h5555_5555, 16'h0001);
    send_item(32'hAAAA_AAAA, 16'h8000);
    send_item(32'h6000_0000, 16'hAAAA);
    send_item(32'hE000_0000, 16'h5555);
    drain();
  endtask

  task automatic test_term_counts();
    logic [2:0] order[9];
    order = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1};
    foreach (order[i]) begin
      write_harmonics(order[i]);
      repeat (30) send_item($urandom, 16'($urandom));
      send_item(32'hC000_0000, 16'hFFFF);
      drain();
    end
    write_harmonics(3'd6);
  endtask

  task automatic test_backpressure();
    int hold;
    rx_hold = 1'b1;
    fork
      begin
        hold = $urandom_range(80, 120);
        repeat (hold) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (60) send_item($urandom, 16'($urandom), 0);
    join
    drain();
  endtask

  task automatic test_random();
    logic [15:0] e;
    rx_no_stall = 1'b1;
    repeat (60) send_item($urandom, 16'($urandom), 0);
    rx_no_stall = 1'b0;
    for (int i = 0; i < 130; i++) begin
      case ($urandom_range(0, 3))
        0: e = 16'($urandom_range(0, 255));
        1: e = 16'($urandom_range(16'hF000, 16'hFFFF));
        default: e = 16'($urandom);
      endcase
      send_item($urandom, e);
    end
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    harmonics = 3'd6;
    err_cnt = 0;
    cyc = 0;
    rx_hold = 1'b0;
    rx_no_stall = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_term_counts();
    test_backpressure();
    test_random();
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
